@@ design/kvls_pkg.sv @@
// kvls_pkg: shared types, constants and a string helper for the key-value table
// no dependencies; used by key_value_table_linear_search and its test bench

package kvls_pkg;

  // table geometry
  localparam int TABLE_DEPTH = 64;
  localparam int KEY_BYTES   = 8;
  localparam int VALUE_BYTES = 8;

  // fixed field widths
  localparam int KEY_W   = 64;
  localparam int VALUE_W = 64;
  localparam int INDEX_W = 6;
  localparam int OCNT_W  = 7;

  // derived storage widths
  localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int PTR_W  = ADDR_W + 1;

  typedef enum logic [1:0] {
    KIND_SET    = 2'd0,
    KIND_LOOKUP = 2'd1,
    KIND_CLEAR  = 2'd2,
    KIND_READ   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_ABSENT = 2'd1,
    STATUS_FULL   = 2'd2
  } status_t;

  typedef struct packed {
    kind_t                kind;
    logic [KEY_W-1:0]     key;
    logic [VALUE_W-1:0]   value;
    logic [INDEX_W-1:0]   index;
  } in_t;

  typedef struct packed {
    status_t              status;
    logic [KEY_W-1:0]     key_out;
    logic [VALUE_W-1:0]   value_out;
    logic [OCNT_W-1:0]    entry_count;
  } out_t;

  // cut a packed string at its first zero byte and at max_bytes characters
  function automatic logic [63:0] trim_string(logic [63:0] raw, int unsigned max_bytes);
    logic [63:0] res;
    logic        ended;
    res   = '0;
    ended = 1'b0;
    for (int pos = 0; pos < 8; pos++) begin
      if (pos >= max_bytes || raw[8*pos +: 8] == 8'h00) begin
        ended = 1'b1;
      end
      if (!ended) begin
        res[8*pos +: 8] = raw[8*pos +: 8];
      end
    end
    return res;
  endfunction

endpackage

@@ design/kvls_ram.sv @@
// kvls_ram: generic single-write, single-read synchronous ram with registered read
// no dependencies

module kvls_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ design/key_value_table_linear_search.sv @@
// key_value_table_linear_search: key-value table with linear key scan (kvls_pkg, kvls_ram)
// clear answers straight from idle, read-at-index fetches the entry in S_FETCH, set/lookup scan
//   from entry 0 up to a hit or the last entry, one stored key compared per cycle through the ram port
// busy is high while a request is in work; a new request may start in the cycle
//   its predecessor's result is strobed; the receiver cannot stall
// reset (rst_n, synchronous) empties the table; ram contents are not cleared

module key_value_table_linear_search (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  kvls_pkg::in_t  in_data,
  output logic           out_valid,
  output kvls_pkg::out_t out_data
);

  // controller states
  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SCAN  = 3'b010,
    S_FETCH = 3'b100
  } state_t;

  state_t                          state_r, state_nxt;
  logic [kvls_pkg::CNT_W-1:0]      count_r, count_nxt;
  logic [kvls_pkg::ADDR_W-1:0]     ptr_r, ptr_nxt;      // entry whose data is on the ram output
  kvls_pkg::in_t                   req_r, req_nxt;      // request with trimmed strings
  kvls_pkg::in_t                   req_in;
  kvls_pkg::out_t                  out_r, out_nxt;
  logic                            out_valid_r, out_valid_nxt;

  // ram ports, both stores addressed in lockstep
  logic                            key_we, val_we;
  logic [kvls_pkg::ADDR_W-1:0]     wr_addr, rd_addr;
  logic [kvls_pkg::KEY_W-1:0]      key_wdata, key_rd;
  logic [kvls_pkg::VALUE_W-1:0]    val_wdata, val_rd;

  logic                            accept;
  logic                            hit;
  logic                            last_entry;
  logic                            table_full;

  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r != S_IDLE);

  // normalize strings on the way in so stored and compared keys never carry padding junk
  always_comb begin
    req_in       = in_data;
    req_in.key   = kvls_pkg::trim_string(in_data.key, kvls_pkg::KEY_BYTES);
    req_in.value = kvls_pkg::trim_string(in_data.value, kvls_pkg::VALUE_BYTES);
  end

  assign hit        = (key_rd == req_r.key);
  assign last_entry = ((kvls_pkg::PTR_W'(ptr_r) + 1'b1) == kvls_pkg::PTR_W'(count_r));
  assign table_full = (count_r == kvls_pkg::CNT_W'(kvls_pkg::TABLE_DEPTH));

  kvls_ram #(
    .WIDTH (kvls_pkg::KEY_W),
    .DEPTH (kvls_pkg::TABLE_DEPTH)
  ) u_key_ram (
    .clk     (clk),
    .wr_en   (key_we),
    .wr_addr (wr_addr),
    .wr_data (key_wdata),
    .rd_addr (rd_addr),
    .rd_data (key_rd)
  );

  kvls_ram #(
    .WIDTH (kvls_pkg::VALUE_W),
    .DEPTH (kvls_pkg::TABLE_DEPTH)
  ) u_val_ram (
    .clk     (clk),
    .wr_en   (val_we),
    .wr_addr (wr_addr),
    .wr_data (val_wdata),
    .rd_addr (rd_addr),
    .rd_data (val_rd)
  );

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ptr_nxt       = ptr_r;
    req_nxt       = req_r;
    out_valid_nxt = 1'b0;
    out_nxt       = '0;
    key_we        = 1'b0;
    val_we        = 1'b0;
    wr_addr       = '0;
    key_wdata     = req_r.key;
    val_wdata     = req_r.value;
    rd_addr       = '0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          req_nxt = req_in;
          case (req_in.kind)
            kvls_pkg::KIND_CLEAR: begin
              count_nxt      = '0;
              out_valid_nxt  = 1'b1;
              out_nxt.status = kvls_pkg::STATUS_OK;
            end
            kvls_pkg::KIND_READ: begin
              if (32'(req_in.index) < 32'(count_r)) begin
                rd_addr   = kvls_pkg::ADDR_W'(req_in.index);
                state_nxt = S_FETCH;
              end else begin
                out_valid_nxt  = 1'b1;
                out_nxt.status = kvls_pkg::STATUS_ABSENT;
              end
            end
            default: begin
              // set or lookup
              if (count_r == '0) begin
                // empty table: nothing to scan
                out_valid_nxt = 1'b1;
                if (req_in.kind == kvls_pkg::KIND_SET) begin
                  key_we         = 1'b1;
                  val_we         = 1'b1;
                  wr_addr        = '0;
                  key_wdata      = req_in.key;
                  val_wdata      = req_in.value;
                  count_nxt      = kvls_pkg::CNT_W'(1);
                  out_nxt.status = kvls_pkg::STATUS_OK;
                end else begin
                  out_nxt.status = kvls_pkg::STATUS_ABSENT;
                end
              end else begin
                rd_addr   = '0;
                ptr_nxt   = '0;
                state_nxt = S_SCAN;
              end
            end
          endcase
        end
      end

      S_SCAN: begin
        // entry ptr_r is on the ram outputs, next one is being fetched
        rd_addr = ptr_r + 1'b1;
        ptr_nxt = ptr_r + 1'b1;
        if (hit) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          out_nxt.status = kvls_pkg::STATUS_OK;
          if (req_r.kind == kvls_pkg::KIND_SET) begin
            // update value in place
            val_we  = 1'b1;
            wr_addr = ptr_r;
          end else begin
            out_nxt.value_out = val_rd;
          end
        end else if (last_entry) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          if (req_r.kind == kvls_pkg::KIND_SET) begin
            if (table_full) begin
              out_nxt.status = kvls_pkg::STATUS_FULL;
            end else begin
              // append behind the last entry
              key_we         = 1'b1;
              val_we         = 1'b1;
              wr_addr        = kvls_pkg::ADDR_W'(count_r);
              count_nxt      = count_r + 1'b1;
              out_nxt.status = kvls_pkg::STATUS_OK;
            end
          end else begin
            out_nxt.status = kvls_pkg::STATUS_ABSENT;
          end
        end
      end

      S_FETCH: begin
        state_nxt         = S_IDLE;
        out_valid_nxt     = 1'b1;
        out_nxt.status    = kvls_pkg::STATUS_OK;
        out_nxt.key_out   = key_rd;
        out_nxt.value_out = val_rd;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // every result reports the count after the request
    out_nxt.entry_count = kvls_pkg::OCNT_W'(count_nxt);
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    ptr_r <= ptr_nxt;
    req_r <= req_nxt;
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

@@ test/key_value_table_linear_search_test.sv @@
// key_value_table_linear_search_test: self-checking bench for the key-value table
// runs a directed table (reset, extremes, full table) then phased random requests
// depends on kvls_pkg and the key_value_table_linear_search rtl

module key_value_table_linear_search_test;
  timeunit 1ns;
  timeprecision 1ps;

  // one row of the directed plan
  typedef struct {
    kvls_pkg::in_t  req;
    bit             typed;       // result typed in below, else taken from the table model
    kvls_pkg::out_t result;
    bit             fill_first;  // top the table up to full before this row
  } plan_row_t;

  logic           clk;
  logic           rst_n;
  logic           start;
  logic           busy;
  kvls_pkg::in_t  in_data;
  logic           out_valid;
  kvls_pkg::out_t out_data;

  // mirror of the table contents, kept in request order
  logic [63:0] key_mem [kvls_pkg::TABLE_DEPTH];
  logic [63:0] val_mem [kvls_pkg::TABLE_DEPTH];
  int          n_entries;

  kvls_pkg::out_t pending_results [$];
  plan_row_t      plan [$];
  logic [63:0]    key_pool [80];
  int             errors;

  key_value_table_linear_search u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // hard stop in case the block hangs or stops answering
  initial begin
    #4_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // cut a packed string at its first nul byte and at max_bytes characters
  function automatic logic [63:0] cut_string(logic [63:0] raw, int max_bytes);
    logic [63:0] res;
    res = '0;
    for (int b = 0; b < 8 && b < max_bytes; b++) begin
      if (raw[8*b +: 8] == 8'h00) break;
      res[8*b +: 8] = raw[8*b +: 8];
    end
    return res;
  endfunction

  // apply one request to the mirror and return the result it should produce
  function automatic kvls_pkg::out_t apply_request(kvls_pkg::in_t req);
    logic [63:0]    k;
    logic [63:0]    v;
    kvls_pkg::out_t r;
    int             hit;
    k        = cut_string(req.key, kvls_pkg::KEY_BYTES);
    v        = cut_string(req.value, kvls_pkg::VALUE_BYTES);
    r        = '0;
    r.status = kvls_pkg::STATUS_OK;
    hit      = -1;
    for (int i = 0; i < n_entries; i++) begin
      if (hit < 0 && key_mem[i] == k) hit = i;
    end
    case (req.kind)
      kvls_pkg::KIND_SET: begin
        if (hit >= 0) begin
          val_mem[hit] = v;
        end else if (n_entries >= kvls_pkg::TABLE_DEPTH) begin
          r.status = kvls_pkg::STATUS_FULL;
        end else begin
          key_mem[n_entries] = k;
          val_mem[n_entries] = v;
          n_entries++;
        end
      end
      kvls_pkg::KIND_LOOKUP: begin
        if (hit >= 0) r.value_out = val_mem[hit];
        else r.status = kvls_pkg::STATUS_ABSENT;
      end
      kvls_pkg::KIND_CLEAR: begin
        n_entries = 0;
      end
      default: begin
        if (int'(req.index) < n_entries) begin
          r.key_out   = key_mem[req.index];
          r.value_out = val_mem[req.index];
        end else begin
          r.status = kvls_pkg::STATUS_ABSENT;
        end
      end
    endcase
    r.entry_count = n_entries[kvls_pkg::OCNT_W-1:0];
    return r;
  endfunction

  function automatic kvls_pkg::in_t make_req(kvls_pkg::kind_t kind, logic [63:0] key,
                                             logic [63:0] value,
                                             logic [kvls_pkg::INDEX_W-1:0] index);
    kvls_pkg::in_t r;
    r.kind  = kind;
    r.key   = key;
    r.value = value;
    r.index = index;
    return r;
  endfunction

  function automatic kvls_pkg::out_t make_res(kvls_pkg::status_t status, logic [63:0] key_out,
                                              logic [63:0] value_out, int count);
    kvls_pkg::out_t r;
    r.status      = status;
    r.key_out     = key_out;
    r.value_out   = value_out;
    r.entry_count = count[kvls_pkg::OCNT_W-1:0];
    return r;
  endfunction

  task automatic add_row(kvls_pkg::in_t req, bit typed, kvls_pkg::out_t result,
                         bit fill_first);
    plan_row_t row;
    row.req        = req;
    row.typed      = typed;
    row.result     = result;
    row.fill_first = fill_first;
    plan.push_back(row);
  endtask

  // random string of 0..8 nonzero bytes
  function automatic logic [63:0] rand_string();
    logic [63:0] s;
    int          len;
    s   = '0;
    len = $urandom_range(8);
    for (int b = 0; b < len; b++) s[8*b +: 8] = 8'($urandom_range(255, 1));
    return s;
  endfunction

  // half the time put random junk above the terminating nul
  function automatic logic [63:0] add_junk(logic [63:0] s);
    logic [63:0] junk;
    int          len;
    len  = 8;
    junk = {$urandom, $urandom};
    for (int b = 7; b >= 0; b--) begin
      if (s[8*b +: 8] == 8'h00) len = b;
    end
    if (len < 8 && $urandom_range(1)) begin
      for (int b = len + 1; b < 8; b++) s[8*b +: 8] = junk[8*b +: 8];
    end
    return s;
  endfunction

  // present one request, wait for the table to take it, then log its result
  task automatic issue(kvls_pkg::in_t req, int idle_pct, bit typed,
                       kvls_pkg::out_t typed_result);
    kvls_pkg::out_t predicted;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (busy !== 1'b0);
    // taken at this edge: mirror it now so order matches the block
    predicted = apply_request(req);
    pending_results.push_back(typed ? typed_result : predicted);
  endtask

  task automatic check_field(string field, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
      errors++;
    end
  endtask

  // results come for exactly one cycle and cannot be held off
  always @(posedge clk) begin : result_check
    kvls_pkg::out_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %h", $time, out_data);
        errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", 64'(want.status), 64'(out_data.status));
        check_field("key_out", want.key_out, out_data.key_out);
        check_field("value_out", want.value_out, out_data.value_out);
        check_field("entry_count", 64'(want.entry_count), 64'(out_data.entry_count));
      end
    end
  end

  initial begin : stimulus
    kvls_pkg::in_t  req;
    kvls_pkg::out_t none;
    int             pick;
    int             idle_pct;
    int             clear_pm;
    logic [63:0]    k;

    errors    = 0;
    n_entries = 0;
    none      = '0;
    rst_n     = 1'b0;
    start     = 1'b0;
    in_data   = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table right after reset
    add_row(make_req(kvls_pkg::KIND_LOOKUP, '0, '0, '0), 1,
            make_res(kvls_pkg::STATUS_ABSENT, '0, '0, 0), 0);
    add_row(make_req(kvls_pkg::KIND_READ, '1, '1, 6'd0), 1,
            make_res(kvls_pkg::STATUS_ABSENT, '0, '0, 0), 0);
    add_row(make_req(kvls_pkg::KIND_READ, '0, '0, 6'd63), 1,
            make_res(kvls_pkg::STATUS_ABSENT, '0, '0, 0), 0);
    // the empty string works as an ordinary key
    add_row(make_req(kvls_pkg::KIND_SET, '0, 64'h41, '0), 1,
            make_res(kvls_pkg::STATUS_OK, '0, '0, 1), 0);
    add_row(make_req(kvls_pkg::KIND_LOOKUP, '0, '1, '1), 1,
            make_res(kvls_pkg::STATUS_OK, '0, 64'h41, 1), 0);
    // junk above the nul is dropped; full-width value has no nul at all
    add_row(make_req(kvls_pkg::KIND_SET, 64'hFFFF_FF00_0000_6261, '1, '0), 1,
            make_res(kvls_pkg::STATUS_OK, '0, '0, 2), 0);
    add_row(make_req(kvls_pkg::KIND_LOOKUP, 64'h6261, '0, '0), 1,
            make_res(kvls_pkg::STATUS_OK, '0, '1, 2), 0);
    add_row(make_req(kvls_pkg::KIND_READ, '0, '0, 6'd1), 1,
            make_res(kvls_pkg::STATUS_OK, 64'h6261, '1, 2), 0);
    add_row(make_req(kvls_pkg::KIND_SET, '1, 64'hFFFF_0000_0000_00FF, '0), 1,
            make_res(kvls_pkg::STATUS_OK, '0, '0, 3), 0);
    // update of an existing key keeps the count
    add_row(make_req(kvls_pkg::KIND_SET, 64'h6261, 64'h7A7A, '1), 1,
            make_res(kvls_pkg::STATUS_OK, '0, '0, 3), 0);
    add_row(make_req(kvls_pkg::KIND_LOOKUP, 64'h1234_0000_0000_6261, '0, '0), 1,
            make_res(kvls_pkg::STATUS_OK, '0, 64'h7A7A, 3), 0);
    add_row(make_req(kvls_pkg::KIND_READ, '0, '0, 6'd2), 1,
            make_res(kvls_pkg::STATUS_OK, '1, 64'hFF, 3), 0);
    add_row(make_req(kvls_pkg::KIND_READ, '0, '0, 6'd3), 1,
            make_res(kvls_pkg::STATUS_ABSENT, '0, '0, 3), 0);
    add_row(make_req(kvls_pkg::KIND_CLEAR, '1, '1, '1), 1,
            make_res(kvls_pkg::STATUS_OK, '0, '0, 0), 0);
    add_row(make_req(kvls_pkg::KIND_LOOKUP, 64'h6261, '0, '0), 1,
            make_res(kvls_pkg::STATUS_ABSENT, '0, '0, 0), 0);
    add_row(make_req(kvls_pkg::KIND_READ, '0, '0, 6'd0), 1,
            make_res(kvls_pkg::STATUS_ABSENT, '0, '0, 0), 0);
    // leading nul: same as the empty key
    add_row(make_req(kvls_pkg::KIND_SET, 64'hFFFF_FFFF_FFFF_FF00, 64'h5, '0), 1,
            make_res(kvls_pkg::STATUS_OK, '0, '0, 1), 0);
    // full table: new key refused, existing key still updated
    add_row(make_req(kvls_pkg::KIND_SET, 64'h7878, 64'h1, '0), 1,
            make_res(kvls_pkg::STATUS_FULL, '0, '0, 64), 1);
    add_row(make_req(kvls_pkg::KIND_SET, 64'hAB00, 64'h9, '0), 1,
            make_res(kvls_pkg::STATUS_OK, '0, '0, 64), 0);
    add_row(make_req(kvls_pkg::KIND_READ, '0, '0, 6'd63), 0, none, 0);
    add_row(make_req(kvls_pkg::KIND_LOOKUP, 64'h7878, '0, '0), 1,
            make_res(kvls_pkg::STATUS_ABSENT, '0, '0, 64), 0);
    add_row(make_req(kvls_pkg::KIND_READ, '0, '0, 6'd0), 1,
            make_res(kvls_pkg::STATUS_OK, '0, 64'h9, 64), 0);
    add_row(make_req(kvls_pkg::KIND_LOOKUP, 64'h6B_40, '0, '0), 0, none, 0);
    add_row(make_req(kvls_pkg::KIND_CLEAR, '0, '0, '0), 1,
            make_res(kvls_pkg::STATUS_OK, '0, '0, 0), 0);

    foreach (plan[r]) begin
      if (plan[r].fill_first) begin
        // keys "k\x01", "k\x02", ... until the table holds TABLE_DEPTH entries
        for (int i = 1; n_entries < kvls_pkg::TABLE_DEPTH; i++) begin
          issue(make_req(kvls_pkg::KIND_SET, 64'h6B | (64'(i) << 8), 64'(i), '0), 0, 0, none);
        end
      end
      issue(plan[r].req, 0, plan[r].typed, plan[r].result);
    end

    // keys drawn mostly from a fixed pool so sets, lookups and updates meet
    foreach (key_pool[p]) key_pool[p] = rand_string();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  clear_pm = 40; end
        1: begin idle_pct = 62; clear_pm = 10; end
        2: begin idle_pct = 26; clear_pm = 40; end
        default: begin idle_pct = 0; clear_pm = 3; end
      endcase
      for (int n = 0; n < 350; n++) begin
        if ($urandom_range(99) < 80) k = key_pool[$urandom_range(79)];
        else k = rand_string();
        req.key   = add_junk(k);
        req.value = {$urandom, $urandom};
        req.index = kvls_pkg::INDEX_W'($urandom);
        pick      = $urandom_range(999);
        if (pick < clear_pm) begin
          req.kind = kvls_pkg::KIND_CLEAR;
        end else if (pick < 430) begin
          req.kind  = kvls_pkg::KIND_SET;
          req.value = add_junk(rand_string());
        end else if (pick < 780) begin
          req.kind = kvls_pkg::KIND_LOOKUP;
        end else begin
          req.kind = kvls_pkg::KIND_READ;
          // mostly aim at or just past the stored entries
          if ($urandom_range(99) < 70) begin
            req.index = kvls_pkg::INDEX_W'($urandom_range(n_entries));
          end
        end
        issue(req, idle_pct, 0, none);
      end
    end
    start <= 1'b0;

    // drain: every request answers once, then wait out the longest scan
    while (pending_results.size() != 0) @(posedge clk);
    repeat (kvls_pkg::TABLE_DEPTH + 8) @(posedge clk);

    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
